/* rtl/jpv_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpv_pkg
// Shared types, codes and arithmetic helpers of the jump peak/valley detector.
// ----------------------------------------------------------------------------
package jpv_pkg;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_RISE = 2'd1;
  localparam logic [1:0] PH_FALL = 2'd2;

  localparam logic [2:0] REG_THR_FACTOR = 3'd0;
  localparam logic [2:0] REG_MIN_INTERVAL = 3'd1;
  localparam logic [2:0] REG_BASE_WINDOW = 3'd2;
  localparam logic [2:0] REG_WINDOW_STEP = 3'd3;
  localparam logic [2:0] REG_TOLERANCE = 3'd4;
  localparam logic [2:0] REG_MAX_PHASE = 3'd5;

  localparam logic [14:0] LEVEL_INIT = 15'd1638;
  localparam logic [15:0] LEVEL_MIN = 16'd614;
  localparam logic [15:0] LEVEL_MAX = 16'd16384;
  localparam logic signed [15:0] START_LEVEL = 16'sd614;
  localparam logic [2:0] CAL_TARGET = 3'd5;

  typedef struct packed {
    logic signed [15:0] filt;
    logic [1:0]         phase;
    logic signed [15:0] peak;
    logic signed [15:0] valley;
    logic [31:0]        rise_ms;
    logic [31:0]        fall_ms;
    logic [31:0]        last_ms;
    logic [31:0]        count;
  } chan_t;

  typedef struct packed {
    logic [15:0] min_interval;
    logic [7:0]  tolerance;
    logic [15:0] max_phase;
    logic        calibrated;
  } eval_cfg_t;

  typedef struct packed {
    chan_t       st;
    logic        jumped;
    logic [14:0] avg;
  } eval_res_t;

  function automatic logic signed [15:0] fast_filter(input logic signed [15:0] x,
                                                     input logic signed [15:0] f);
    logic signed [29:0] v;
    v = 30'sd1638 * 30'(x) + 30'sd2458 * 30'(f) + 30'sd2048;
    return v[27:12];
  endfunction

endpackage

/* rtl/jpv_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpv_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module jpv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/jpv_eval.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpv_eval
// Next-state logic of one detector channel: phase machine, peak and valley
// tracking, window checks, threshold test and running average update.
// ----------------------------------------------------------------------------
module jpv_eval
  import jpv_pkg::*;
(
  input  chan_t              st_i,
  input  logic signed [15:0] fv_i,
  input  logic [31:0]        now_i,
  input  logic [15:0]        win_i,
  input  logic [30:0]        prod_i,
  input  logic [42:0]        thr_i,
  input  logic [14:0]        avg_i,
  input  eval_cfg_t          cfg_i,
  output eval_res_t          res_o
);

  logic [16:0]        lo;
  logic [16:0]        hi;
  logic [31:0]        rise_dur;
  logic [31:0]        fall_dur;
  logic signed [15:0] pk;
  logic signed [15:0] vl;
  logic signed [29:0] lhs;
  logic signed [29:0] rhs;
  logic               drop;
  logic               rise_in;
  logic               fall_in;
  logic signed [16:0] d;
  logic [16:0]        diff;
  logic               over;
  logic [27:0]        sum;
  logic [15:0]        a;
  logic [15:0]        a_cl;

  always_comb begin
    lo = (win_i > 16'(cfg_i.tolerance)) ? 17'(win_i - 16'(cfg_i.tolerance)) : 17'd0;
    hi = 17'(win_i) + 17'(cfg_i.tolerance);
    rise_dur = now_i - st_i.rise_ms;
    fall_dur = now_i - st_i.fall_ms;
    rise_in = (rise_dur >= 32'(lo)) && (rise_dur <= 32'(hi));
    fall_in = (fall_dur >= 32'(lo)) && (fall_dur <= 32'(hi));
    pk = (fv_i > st_i.peak) ? fv_i : st_i.peak;
    vl = (fv_i < st_i.valley) ? fv_i : st_i.valley;
    lhs = {{2{fv_i[15]}}, fv_i, 12'b0};
    rhs = 30'(pk) * 30'sd3482;
    drop = lhs < rhs;
    d = 17'(st_i.peak) - 17'(vl);
    diff = d[16] ? 17'(-d) : 17'(d);
    if (cfg_i.calibrated) begin
      over = {2'b0, diff, 12'b0} > prod_i;
    end else begin
      over = {3'b0, diff, 24'b0} > {1'b0, thr_i};
    end
    sum = 28'd3768 * 28'(avg_i) + 28'd328 * 28'(diff) + 28'd2048;
    a = sum[27:12];
    a_cl = (a < LEVEL_MIN) ? LEVEL_MIN : ((a > LEVEL_MAX) ? LEVEL_MAX : a);

    res_o.st = st_i;
    res_o.st.filt = fv_i;
    res_o.jumped = 1'b0;
    res_o.avg = avg_i;
    unique case (st_i.phase)
      PH_RISE: begin
        res_o.st.peak = pk;
        if (drop) begin
          if (rise_in) begin
            res_o.st.phase = PH_FALL;
            res_o.st.fall_ms = now_i;
            res_o.st.valley = fv_i;
          end else begin
            res_o.st.phase = PH_IDLE;
          end
        end else if (rise_dur > 32'(cfg_i.max_phase)) begin
          res_o.st.phase = PH_IDLE;
        end
      end
      PH_FALL: begin
        res_o.st.valley = vl;
        if (fall_in) begin
          if (over && ((now_i - st_i.last_ms) > 32'(cfg_i.min_interval))) begin
            res_o.st.count = st_i.count + 32'd1;
            res_o.st.last_ms = now_i;
            res_o.avg = a_cl[14:0];
            res_o.jumped = 1'b1;
          end
          res_o.st.phase = PH_IDLE;
        end else if (fall_dur > 32'(cfg_i.max_phase)) begin
          res_o.st.phase = PH_IDLE;
        end
      end
      default: begin
        res_o.st.phase = PH_IDLE;
        if (fv_i > st_i.filt && fv_i > START_LEVEL) begin
          res_o.st.phase = PH_RISE;
          res_o.st.rise_ms = now_i;
          res_o.st.peak = fv_i;
        end
      end
    endcase
  end

endmodule

/* rtl/jump_peak_valley_detector.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jump_peak_valley_detector
// Multi-window jump counter on vertical acceleration with per-channel state
// held in a synchronous RAM and a shared adaptive jump threshold.
// ----------------------------------------------------------------------------
//  Channel  Signals                                     Handshake
//  input    mode_i, sample_i, time_ms_i                 in_valid_i / in_ready_o
//  result   jump_flags_o, reference_count_o,            out_valid_o / out_ready_i
//           calibrated_o, avg_jump_level_o
//  config   cfg_idx_i, cfg_wdata_i                      cfg_we_i, no wait
//
// For each channel a sample passes through a RAM read, a filter step and an
// evaluate and write-back step. Reset marks every RAM entry as cleared.
// A new item is taken once the previous result has moved to the output
// register; a stalled output holds the block in its final cycle.
module jump_peak_valley_detector
  import jpv_pkg::*;
#(
  parameter int CHANNELS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic signed [15:0] sample_i,
  input  logic [31:0]        time_ms_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [3:0]         jump_flags_o,
  output logic [31:0]        reference_count_o,
  output logic               calibrated_o,
  output logic [14:0]        avg_jump_level_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SW = $bits(chan_t);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD = 3'd1;
  localparam logic [2:0] ST_FILT = 3'd2;
  localparam logic [2:0] ST_EVAL = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [CH_W-1:0]    ch_q, ch_d;
  logic [CHANNELS-1:0] vld_q, vld_d;
  logic [15:0]        thr_factor_q, min_int_q, max_phase_q;
  logic [11:0]        base_win_q;
  logic [7:0]         win_step_q, tol_q;
  logic [14:0]        avg_q, avg_d;
  logic [2:0]         cal_cnt_q, cal_cnt_d;
  logic               cal_q, cal_d;
  logic [31:0]        ref_q, ref_d;
  logic [3:0]         flags_q, flags_d;
  logic signed [15:0] sample_q;
  logic [31:0]        time_q;
  logic signed [15:0] fv_q;
  logic [30:0]        prod_q;
  logic [42:0]        thr_q;
  logic               out_valid_q;
  logic [3:0]         out_flags_q;
  logic [31:0]        out_ref_q;
  logic               out_cal_q;
  logic [14:0]        out_avg_q;

  logic               in_fire;
  logic               ram_we;
  logic               ram_re;
  logic [SW-1:0]      ram_rdata;
  chan_t              st;
  logic [15:0]        win;
  eval_cfg_t          ecfg;
  eval_res_t          ev;
  logic               out_load;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire = in_valid_i && in_ready_o;
  assign ram_re = (state_q == ST_RD);
  assign ram_we = (state_q == ST_EVAL);
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  jpv_ram #(
    .WIDTH(SW),
    .DEPTH(CHANNELS),
    .AW   (CH_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (ch_q),
    .wdata_i(ev.st),
    .rdata_o(ram_rdata)
  );

  assign st = vld_q[ch_q] ? chan_t'(ram_rdata) : chan_t'('0);
  assign win = 16'(base_win_q) + 16'(ch_q) * 16'(win_step_q);
  assign ecfg = '{min_interval: min_int_q, tolerance: tol_q, max_phase: max_phase_q,
                  calibrated: cal_q};

  jpv_eval u_eval (
    .st_i (st),
    .fv_i (fv_q),
    .now_i(time_q),
    .win_i(win),
    .prod_i(prod_q),
    .thr_i(thr_q),
    .avg_i(avg_q),
    .cfg_i(ecfg),
    .res_o(ev)
  );

  always_comb begin
    state_d = state_q;
    ch_d = ch_q;
    vld_d = vld_q;
    avg_d = avg_q;
    cal_cnt_d = cal_cnt_q;
    cal_d = cal_q;
    ref_d = ref_q;
    flags_d = flags_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          flags_d = '0;
          ch_d = '0;
          if (mode_i) begin
            vld_d = '0;
            avg_d = LEVEL_INIT;
            cal_cnt_d = '0;
            cal_d = 1'b0;
            ref_d = '0;
            state_d = ST_DONE;
          end else begin
            state_d = ST_RD;
          end
        end
      end
      ST_RD: state_d = ST_FILT;
      ST_FILT: state_d = ST_EVAL;
      ST_EVAL: begin
        vld_d[ch_q] = 1'b1;
        avg_d = ev.avg;
        flags_d = flags_q | (4'(ev.jumped) << ch_q);
        if (ev.jumped && !cal_q) begin
          cal_cnt_d = cal_cnt_q + 3'd1;
          cal_d = (cal_cnt_q + 3'd1) >= CAL_TARGET;
        end
        if (32'(ch_q) == 32'd2) begin
          ref_d = ev.st.count;
        end
        if (32'(ch_q) == CHANNELS - 1) begin
          state_d = ST_DONE;
        end else begin
          ch_d = ch_q + CH_W'(1);
          state_d = ST_RD;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ch_q <= '0;
      vld_q <= '0;
      avg_q <= LEVEL_INIT;
      cal_cnt_q <= '0;
      cal_q <= 1'b0;
      ref_q <= '0;
      flags_q <= '0;
      out_valid_q <= 1'b0;
      thr_factor_q <= 16'd5325;
      min_int_q <= 16'd300;
      base_win_q <= 12'd180;
      win_step_q <= 8'd10;
      tol_q <= 8'd40;
      max_phase_q <= 16'd800;
    end else begin
      state_q <= state_d;
      ch_q <= ch_d;
      vld_q <= vld_d;
      avg_q <= avg_d;
      cal_cnt_q <= cal_cnt_d;
      cal_q <= cal_d;
      ref_q <= ref_d;
      flags_q <= flags_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_THR_FACTOR:   thr_factor_q <= cfg_wdata_i;
          REG_MIN_INTERVAL: min_int_q <= cfg_wdata_i;
          REG_BASE_WINDOW:  base_win_q <= cfg_wdata_i[11:0];
          REG_WINDOW_STEP:  win_step_q <= cfg_wdata_i[7:0];
          REG_TOLERANCE:    tol_q <= cfg_wdata_i[7:0];
          REG_MAX_PHASE:    max_phase_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sample_q <= sample_i;
      time_q <= time_ms_i;
    end
    if (state_q == ST_RD) begin
      prod_q <= 31'(avg_q) * 31'(thr_factor_q);
    end
    if (state_q == ST_FILT) begin
      fv_q <= fast_filter(sample_q, st.filt);
      thr_q <= 43'(prod_q) * 43'd2867;
    end
    if (out_load) begin
      out_flags_q <= flags_q;
      out_ref_q <= ref_q;
      out_cal_q <= cal_q;
      out_avg_q <= avg_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign jump_flags_o = out_flags_q;
  assign reference_count_o = out_ref_q;
  assign calibrated_o = out_cal_q;
  assign avg_jump_level_o = out_avg_q;

  a_avg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (avg_q >= 15'(LEVEL_MIN)) && (avg_q <= 15'(LEVEL_MAX)))
    else $error("average level left its clamp range");

  a_cal_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cal_q == (cal_cnt_q >= CAL_TARGET))
    else $error("calibration flag disagrees with jump count");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("block ready right after a transfer");

  a_result_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_valid_o && state_q == ST_IDLE))
    else $error("result not presented after completion");

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Jump peak/valley detector testbench
// Drives timestamped acceleration samples and session clears through the
// valid/ready input channel and checks every result transfer against a
// fixed-point model of the four detectors and the shared jump average.
// Directed rows cover reset, clear and field extremes. Random phases then
// send synthetic jump waveforms and noise under several register settings.
// ----------------------------------------------------------------------------
module tb;
  import jpv_pkg::*;

  localparam int NCH = 4;

  typedef struct {
    logic        mode;
    logic [15:0] sample;
    logic [31:0] tms;
  } sample_t;

  typedef struct packed {
    logic [3:0]  flags;
    logic [31:0] ref_count;
    logic        cal;
    logic [14:0] avg;
  } jump_rpt_t;

  typedef struct {
    sample_t   s;
    logic      known;
    jump_rpt_t r;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic mode_i = 1'b0;
  logic signed [15:0] sample_i = '0;
  logic [31:0] time_ms_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [3:0] jump_flags_o;
  logic [31:0] reference_count_o;
  logic calibrated_o;
  logic [14:0] avg_jump_level_o;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [15:0] cfg_wdata_i = '0;

  jump_peak_valley_detector #(.CHANNELS(NCH)) u_dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Detector model state.
  logic [15:0] thr_factor, min_gap, max_phase;
  logic [11:0] base_win;
  logic [7:0] win_step, tol;
  logic signed [15:0] filt[NCH], prev_filt[NCH], peak[NCH], valley[NCH];
  logic [1:0] ph[NCH];
  logic [31:0] rise_ms[NCH], fall_ms[NCH], last_ms[NCH], jcount[NCH];
  logic [14:0] avg_level;
  int unsigned cal_jumps;
  logic cal_done;

  jump_rpt_t expected_rpts[$];
  int errors = 0;
  bit hold_out = 1'b0;
  bit stall_done = 1'b0;

  function automatic void clear_detectors();
    for (int c = 0; c < NCH; c++) begin
      filt[c] = 0; prev_filt[c] = 0; peak[c] = 0; valley[c] = 0;
      ph[c] = PH_IDLE; rise_ms[c] = 0; fall_ms[c] = 0; last_ms[c] = 0; jcount[c] = 0;
    end
    avg_level = LEVEL_INIT;
    cal_jumps = 0;
    cal_done = 1'b0;
  endfunction

  function automatic bit fits_window(logic [31:0] dur, longint unsigned w);
    longint unsigned lo, hi;
    lo = (w > tol) ? w - tol : 0;
    hi = w + tol;
    return dur >= lo && dur <= hi;
  endfunction

  function automatic jump_rpt_t predict_jumps(sample_t s);
    jump_rpt_t r;
    longint x, fv, d, diff, prod, a, w;
    logic [31:0] dur;
    logic [1:0] nxt;
    bit over;
    r.flags = '0;
    if (s.mode) begin
      clear_detectors();
    end else begin
      x = longint'($signed(s.sample));
      for (int c = 0; c < NCH; c++) begin
        fv = (1638 * x + 2458 * longint'(filt[c]) + 2048) >>> 12;
        w = longint'(base_win) + c * longint'(win_step);
        nxt = ph[c];
        filt[c] = fv[15:0];
        if (ph[c] == PH_RISE) begin
          dur = s.tms - rise_ms[c];
          if (fv > peak[c]) peak[c] = fv[15:0];
          if (fv * 4096 < longint'(peak[c]) * 3482) begin
            if (fits_window(dur, w)) begin
              nxt = PH_FALL; fall_ms[c] = s.tms; valley[c] = fv[15:0];
            end else begin
              nxt = PH_IDLE;
            end
          end
          if (nxt == PH_RISE && dur > max_phase) nxt = PH_IDLE;
        end else if (ph[c] == PH_FALL) begin
          if (fv < valley[c]) valley[c] = fv[15:0];
          dur = s.tms - fall_ms[c];
          if (fits_window(dur, w)) begin
            d = longint'(peak[c]) - longint'(valley[c]);
            diff = d < 0 ? -d : d;
            prod = longint'(avg_level) * longint'(thr_factor);
            if (cal_done) over = diff * 4096 > prod;
            else over = diff * 16777216 > prod * 2867;
            if (over && (s.tms - last_ms[c]) > min_gap) begin
              jcount[c] = jcount[c] + 1;
              last_ms[c] = s.tms;
              a = (3768 * longint'(avg_level) + 328 * diff + 2048) >> 12;
              if (a < LEVEL_MIN) a = LEVEL_MIN;
              if (a > LEVEL_MAX) a = LEVEL_MAX;
              avg_level = a[14:0];
              if (!cal_done) begin
                cal_jumps++;
                if (cal_jumps >= CAL_TARGET) cal_done = 1'b1;
              end
              r.flags[c] = 1'b1;
            end
            nxt = PH_IDLE;
          end else if (dur > max_phase) begin
            nxt = PH_IDLE;
          end
        end else begin
          nxt = PH_IDLE;
          if (fv > prev_filt[c] && fv > START_LEVEL) begin
            nxt = PH_RISE; rise_ms[c] = s.tms; peak[c] = fv[15:0];
          end
        end
        ph[c] = nxt;
        prev_filt[c] = fv[15:0];
      end
    end
    r.ref_count = jcount[2];
    r.cal = cal_done;
    r.avg = avg_level;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_THR_FACTOR:   thr_factor = val;
      REG_MIN_INTERVAL: min_gap = val;
      REG_BASE_WINDOW:  base_win = val[11:0];
      REG_WINDOW_STEP:  win_step = val[7:0];
      REG_TOLERANCE:    tol = val[7:0];
      REG_MAX_PHASE:    max_phase = val;
      default: ;
    endcase
  endtask

  task automatic send_sample(sample_t s, logic known, jump_rpt_t want);
    jump_rpt_t p;
    int unsigned gap;
    gap = $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1; mode_i <= s.mode; sample_i <= s.sample; time_ms_i <= s.tms;
    do @(posedge clk_i); while (!in_ready_o);
    p = predict_jumps(s);
    if (known && p !== want) begin
      $display("directed row disagrees with model at %0t", $realtime);
      errors++;
    end
    expected_rpts.push_back(p);
  endtask

  task automatic drain_settle();
    in_valid_i <= 1'b0;
    while (expected_rpts.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // Result checker and stalling receiver.
  initial begin
    jump_rpt_t e;
    int gap;
    gap = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (expected_rpts.size() == 0) begin
          $display("unexpected result transfer at %0t", $realtime);
          errors++;
        end else begin
          e = expected_rpts.pop_front();
          if (jump_flags_o !== e.flags) report_mismatch("jump_flags", jump_flags_o, e.flags);
          if (reference_count_o !== e.ref_count)
            report_mismatch("reference_count", reference_count_o, e.ref_count);
          if (calibrated_o !== e.cal) report_mismatch("calibrated", calibrated_o, e.cal);
          if (avg_jump_level_o !== e.avg)
            report_mismatch("avg_jump_level", avg_jump_level_o, e.avg);
        end
        gap = $urandom_range(0, 6);
      end
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        gap--;
      end else begin
        out_ready_i <= !hold_out;
      end
    end
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

  // Emits one synthetic jump: a rise lasting about the window, then a longer fall.
  task automatic send_jump(ref logic [31:0] t, input int amp, input int win);
    sample_t s;
    jump_rpt_t z;
    int n;
    s.mode = 1'b0;
    n = $urandom_range(3, 6);
    for (int k = 0; k < n; k++) begin
      s.sample = 16'(amp * (k + 1) / n + $signed($urandom_range(0, 200)) - 100);
      t = t + win / n; s.tms = t;
      send_sample(s, 1'b0, z);
    end
    for (int k = 0; k < 2 * n; k++) begin
      s.sample = 16'(amp - amp * 2 * (k + 1) / n + $signed($urandom_range(0, 200)) - 100);
      t = t + win / n; s.tms = t;
      send_sample(s, 1'b0, z);
    end
    for (int k = 0; k < 3; k++) begin
      s.sample = 16'(-amp / 4 * (2 - k));
      t = t + $urandom_range(20, 120); s.tms = t;
      send_sample(s, 1'b0, z);
    end
  endtask

  initial begin
    row_t rows[$];
    row_t r;
    sample_t s;
    jump_rpt_t z;
    logic [31:0] t;
    int items;
    thr_factor = 5325; min_gap = 300; base_win = 180; win_step = 10; tol = 40;
    max_phase = 800;
    clear_detectors();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    z = '{4'd0, 32'd0, 1'b0, LEVEL_INIT};
    rows.push_back('{'{1'b0, 16'h0000, 32'd0}, 1'b1, z});
    rows.push_back('{'{1'b1, 16'h7fff, 32'hffff_ffff}, 1'b1, z});
    rows.push_back('{'{1'b0, 16'h8000, 32'd5}, 1'b1, z});
    rows.push_back('{'{1'b0, 16'h7fff, 32'd10}, 1'b0, z});
    rows.push_back('{'{1'b0, 16'h7fff, 32'd100}, 1'b0, z});
    rows.push_back('{'{1'b0, 16'h8000, 32'd200}, 1'b0, z});
    rows.push_back('{'{1'b0, 16'h8000, 32'd400}, 1'b0, z});
    rows.push_back('{'{1'b0, 16'h7fff, 32'hffff_ff00}, 1'b0, z});
    rows.push_back('{'{1'b0, 16'h7fff, 32'hffff_ffff}, 1'b0, z});
    rows.push_back('{'{1'b0, 16'h8000, 32'd150}, 1'b0, z});
    rows.push_back('{'{1'b0, 16'h0000, 32'd2000}, 1'b0, z});
    rows.push_back('{'{1'b1, 16'h0000, 32'd0}, 1'b1, z});
    foreach (rows[i]) begin
      r = rows[i];
      send_sample(r.s, r.known, r.r);
    end
    t = 32'd1000;
    repeat (6) send_jump(t, $urandom_range(6000, 20000), 190);
    drain_settle();

    for (int phase_no = 0; phase_no < 5; phase_no++) begin
      case (phase_no)
        0: begin
          write_reg(REG_THR_FACTOR, 16'd0); write_reg(REG_MIN_INTERVAL, 16'd0);
          write_reg(REG_BASE_WINDOW, 16'd0); write_reg(REG_WINDOW_STEP, 16'd0);
          write_reg(REG_TOLERANCE, 16'd0); write_reg(REG_MAX_PHASE, 16'd0);
          write_reg(3'd7, 16'hffff);
        end
        1: begin
          write_reg(REG_THR_FACTOR, 16'hffff); write_reg(REG_MIN_INTERVAL, 16'hffff);
          write_reg(REG_BASE_WINDOW, 16'hffff); write_reg(REG_WINDOW_STEP, 16'hffff);
          write_reg(REG_TOLERANCE, 16'hffff); write_reg(REG_MAX_PHASE, 16'hffff);
        end
        default: begin
          write_reg(REG_THR_FACTOR, 16'($urandom_range(2000, 6000)));
          write_reg(REG_MIN_INTERVAL, 16'($urandom_range(0, 400)));
          write_reg(REG_BASE_WINDOW, 16'($urandom_range(20, 250)));
          write_reg(REG_WINDOW_STEP, 16'($urandom_range(0, 30)));
          write_reg(REG_TOLERANCE, 16'($urandom_range(30, 120)));
          write_reg(REG_MAX_PHASE, 16'($urandom_range(300, 1000)));
        end
      endcase
      items = 0;
      while (items < 80) begin
        if ($urandom_range(0, 9) < 7) begin
          send_jump(t, $urandom_range(2000, 24000), base_win + $urandom_range(0, 30));
          items += 16;
        end else begin
          s.mode = ($urandom_range(0, 15) == 0);
          s.sample = 16'($urandom);
          t = ($urandom_range(0, 9) == 0) ? $urandom : t + $urandom_range(0, 300);
          s.tms = t;
          send_sample(s, 1'b0, z);
          items++;
        end
        if (phase_no == 2 && items > 40 && !stall_done) begin
          stall_done = 1'b1;
          fork
            begin
              hold_out = 1'b1;
              repeat (200) @(posedge clk_i);
              hold_out = 1'b0;
            end
          join_none
        end
      end
      drain_settle();
    end

    if (errors == 0 && expected_rpts.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/jpv_pkg.sv
rtl/jpv_ram.sv
rtl/jpv_eval.sv
rtl/jump_peak_valley_detector.sv
test/tb.sv
